// ===== design/msa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msa_pkg
// Shared types and constants of the max-gap slot allocator.
// ----------------------------------------------------------------------------
package msa_pkg;

    localparam int MAX_SLOTS_DEF = 64;
    localparam int NUM_SLOTS_W   = 7;
    localparam int POS_W         = 6;

    localparam logic [NUM_SLOTS_W-1:0] NUM_SLOTS_RST = 7'd64;

    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    typedef struct packed {
        logic             action;
        logic [POS_W-1:0] position;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0] slot_index;
        logic             full_res;
    } t_out_item;

    typedef struct packed {
        logic shift;
        logic wr;
        logic wr_val;
    } t_cell_ctrl;

    typedef struct packed {
        logic start;
        logic step;
        logic occ;
    } t_scan_ctrl;

endpackage

// ===== design/msa_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msa_cell
// One occupancy bit of the slot ring: shifts from its neighbor or is written.
// ----------------------------------------------------------------------------
module msa_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  msa_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_next,
    output logic                o_bit
);

    logic r_bit;
    logic n_bit;

    always_comb begin
        n_bit = r_bit;
        if (i_ctrl.shift) begin
            n_bit = i_next;
        end else if (i_ctrl.wr) begin
            n_bit = i_ctrl.wr_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else begin
            r_bit <= n_bit;
        end
    end

    assign o_bit = r_bit;

endmodule

// ===== design/msa_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msa_scan
// Gap tracker at the head of the ring: follows the widest gap slot by slot.
// ----------------------------------------------------------------------------
module msa_scan #(
    parameter int IW = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  msa_pkg::t_scan_ctrl i_ctrl,
    input  logic [IW-1:0]       i_idx,
    output logic [IW-1:0]       o_prev,
    output logic [IW-1:0]       o_best,
    output logic [IW-1:0]       o_choice
);

    logic          r_have;
    logic [IW-1:0] r_prev;
    logic [IW-1:0] r_best;
    logic [IW-1:0] r_choice;
    logic          n_have;
    logic [IW-1:0] n_prev;
    logic [IW-1:0] n_best;
    logic [IW-1:0] n_choice;
    logic [IW-1:0] w_half;

    assign w_half = IW'((i_idx - r_prev) >> 1);

    always_comb begin
        n_have   = r_have;
        n_prev   = r_prev;
        n_best   = r_best;
        n_choice = r_choice;
        if (i_ctrl.start) begin
            n_have   = 1'b0;
            n_prev   = '0;
            n_best   = '0;
            n_choice = '0;
        end else if (i_ctrl.step && i_ctrl.occ) begin
            if (!r_have) begin
                n_have = 1'b1;
                n_best = i_idx;
            end else if (w_half > r_best) begin
                n_best   = w_half;
                n_choice = IW'(r_prev + w_half);
            end
            n_prev = i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else begin
            r_have <= n_have;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev   <= n_prev;
        r_best   <= n_best;
        r_choice <= n_choice;
    end

    assign o_prev   = r_prev;
    assign o_best   = r_best;
    assign o_choice = r_choice;

endmodule

// ===== design/max_gap_slot_allocator_unit.sv =====
`timescale 1ns / 1ps
// Release: taken with no result; releases can follow back to back.
// Allocate with the room full or empty: goes from acceptance straight to finish.
// Other allocates: one full turn of the cell ring past the gap tracker, then finish;
// no new item is taken until the allocate's result has been issued.
// A stalled earlier result holds the finish cycle until that result is taken.
// Reset (synchronous, active low) frees every slot, clears the count, num_slots = 64.
// ----------------------------------------------------------------------------
// max_gap_slot_allocator_unit
// Max-gap slot allocator over a rotating ring of occupancy cells.
// ----------------------------------------------------------------------------
module max_gap_slot_allocator_unit #(
    parameter int MAX_SLOTS = msa_pkg::MAX_SLOTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  msa_pkg::t_in_item                   i_in_data,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    output msa_pkg::t_out_item                  o_out_data,
    input  logic                                i_out_stall,
    input  logic                                i_cfg_valid,
    input  logic [msa_pkg::NUM_SLOTS_W-1:0]     i_cfg_data,
    output logic                                o_cfg_ready
);

    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int NW = (CW > msa_pkg::NUM_SLOTS_W) ? CW : msa_pkg::NUM_SLOTS_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]                      r_state;
    logic [1:0]                      n_state;
    logic [IW-1:0]                   r_idx;
    logic [IW-1:0]                   n_idx;
    logic [CW-1:0]                   r_count;
    logic [CW-1:0]                   n_count;
    logic [msa_pkg::NUM_SLOTS_W-1:0] r_num;
    logic                            r_direct;
    logic                            n_direct;
    logic                            r_full;
    logic                            n_full;
    logic                            r_out_valid;
    logic                            n_out_valid;
    msa_pkg::t_out_item              r_out;
    msa_pkg::t_out_item              n_out;

    logic [MAX_SLOTS-1:0]            w_occ;
    msa_pkg::t_cell_ctrl             w_cell_ctrl [MAX_SLOTS];
    msa_pkg::t_scan_ctrl             w_scan_ctrl;
    logic [CW-1:0]                   w_n_eff;
    logic [IW-1:0]                   w_last;
    logic [IW-1:0]                   w_prev;
    logic [IW-1:0]                   w_best;
    logic [IW-1:0]                   w_choice;
    logic                            w_right;
    logic [IW-1:0]                   w_final;
    logic                            w_accept;
    logic                            w_alloc;
    logic [IW-1:0]                   w_pos;
    logic                            w_rel_ok;
    logic                            w_fire;
    logic                            w_mark;
    logic                            w_wr;
    logic                            w_wr_val;
    logic [IW-1:0]                   w_wr_idx;

    assign w_n_eff = (NW'(r_num) > NW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : CW'(r_num);
    assign w_last  = IW'(w_n_eff - CW'(1));

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_alloc     = w_accept && (i_in_data.action == msa_pkg::ACT_ALLOC);
    assign w_pos       = IW'(i_in_data.position);
    assign w_rel_ok    = w_accept && (i_in_data.action == msa_pkg::ACT_RELEASE)
                         && (NW'(i_in_data.position) < NW'(w_n_eff)) && w_occ[w_pos];

    assign w_right = (w_last > w_prev) && (IW'(w_last - w_prev) > w_best);
    assign w_final = r_direct ? '0 : (w_right ? w_last : w_choice);
    assign w_fire  = (r_state == ST_FINISH) && (!r_out_valid || !i_out_stall);
    assign w_mark  = w_fire && !r_full && !w_occ[w_final];

    assign w_wr     = w_rel_ok || w_mark;
    assign w_wr_val = w_mark;
    assign w_wr_idx = w_mark ? w_final : w_pos;

    genvar g;
    generate
        for (g = 0; g < MAX_SLOTS; g++) begin : g_cell
            always_comb begin
                w_cell_ctrl[g].shift  = (r_state == ST_SCAN);
                w_cell_ctrl[g].wr     = w_wr && (w_wr_idx == IW'(g));
                w_cell_ctrl[g].wr_val = w_wr_val;
            end

            msa_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_cell_ctrl[g]),
                .i_next  (w_occ[(g + 1) % MAX_SLOTS]),
                .o_bit   (w_occ[g])
            );
        end
    endgenerate

    assign w_scan_ctrl.start = w_alloc;
    assign w_scan_ctrl.step  = (r_state == ST_SCAN);
    assign w_scan_ctrl.occ   = w_occ[0];

    msa_scan #(
        .IW (IW)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_scan_ctrl),
        .i_idx    (r_idx),
        .o_prev   (w_prev),
        .o_best   (w_best),
        .o_choice (w_choice)
    );

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_count     = r_count;
        n_direct    = r_direct;
        n_full      = r_full;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_rel_ok) begin
                    n_count = r_count - CW'(1);
                end
                if (w_alloc) begin
                    n_idx = '0;
                    if (r_count >= w_n_eff) begin
                        n_full   = 1'b1;
                        n_direct = 1'b1;
                        n_state  = ST_FINISH;
                    end else if (r_count == '0) begin
                        n_full   = 1'b0;
                        n_direct = 1'b1;
                        n_state  = ST_FINISH;
                    end else begin
                        n_full   = 1'b0;
                        n_direct = 1'b0;
                        n_state  = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                n_idx = IW'(r_idx + IW'(1));
                if (r_idx == IW'(MAX_SLOTS - 1)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (w_fire) begin
                    n_out_valid      = 1'b1;
                    n_out.full_res   = r_full;
                    n_out.slot_index = r_full ? '0 : msa_pkg::POS_W'(w_final);
                    if (w_mark) begin
                        n_count = r_count + CW'(1);
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_count     <= '0;
            r_num       <= msa_pkg::NUM_SLOTS_RST;
            r_direct    <= 1'b0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_count     <= n_count;
            r_direct    <= n_direct;
            r_full      <= n_full;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_num <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'($countones(w_occ)) == r_count)
        else $error("occupied count differs from bitmap");

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) && (r_idx == IW'(MAX_SLOTS - 1)) |=> (r_state == ST_FINISH))
        else $error("scan did not end after one ring turn");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_FINISH))
        else $error("result appeared outside finish");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.full_res |-> (o_out_data.slot_index == '0))
        else $error("full result carries a slot index");

    a_mark_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mark |=> w_occ[$past(w_final)])
        else $error("allocated slot not marked");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the max-gap slot allocator.
// A directed table (empty and full room, end and inner gaps, slot counts of
// zero, above capacity and shrunk below the occupied slots, ignored releases)
// runs first. Random phases under many slot counts follow. Every seat result
// is held to a cycle-free model of the seat choice, or to a row's own result;
// both channels idle and stall at random in every phase but one.
// ----------------------------------------------------------------------------
module tb;

    localparam int NSLOT      = 64;
    localparam int SETTLE_CYC = NSLOT + 16;
    localparam int PHASES     = 15;
    localparam int PHASE_LEN  = 90;

    typedef enum logic [1:0] {
        ROW_ALLOC,
        ROW_RELEASE,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind                 kind;
        logic [msa_pkg::POS_W-1:0] pos;
        logic [6:0]                cfg_val;
        bit                        typed;
        msa_pkg::t_out_item        res;
    } t_row;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               in_valid     = 1'b0;
    msa_pkg::t_in_item  in_data      = '0;
    logic               in_typed     = 1'b0;
    msa_pkg::t_out_item in_typed_res = '0;
    logic               out_stall    = 1'b0;
    logic               cfg_valid    = 1'b0;
    logic [6:0]         cfg_data     = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    msa_pkg::t_out_item o_out_data;
    logic               o_cfg_ready;

    bit                 occ_map [NSLOT];
    int                 occ_count    = 0;
    logic [6:0]         slot_cfg     = msa_pkg::NUM_SLOTS_RST;
    msa_pkg::t_out_item pending_seats [$];
    t_row               plan [$];

    bit                 gaps_on      = 1'b1;
    int                 err_count    = 0;
    int                 n_alloc      = 0;
    int                 n_full       = 0;
    int                 n_release    = 0;
    int                 n_cfg        = 0;
    bit                 held_valid   = 1'b0;
    msa_pkg::t_out_item held_data    = '0;

    max_gap_slot_allocator_unit #(.MAX_SLOTS(NSLOT)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .i_cfg_data  (cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    always #6 i_clk = ~i_clk;

    // advance the seat map by one transaction; returns 1 when a result is due
    function automatic bit seat_step(input msa_pkg::t_in_item it,
                                     output msa_pkg::t_out_item res);
        int n;
        int best;
        int prev;
        int choice;
        int d;
        n      = (int'(slot_cfg) > NSLOT) ? NSLOT : int'(slot_cfg);
        res    = '0;
        choice = 0;
        if (it.action == msa_pkg::ACT_RELEASE) begin
            if (int'(it.position) < n && occ_map[it.position]) begin
                occ_map[it.position] = 1'b0;
                occ_count--;
            end
            return 1'b0;
        end
        if (occ_count >= n) begin
            res.full_res = 1'b1;
            return 1'b1;
        end
        if (occ_count != 0) begin
            best = -1;
            prev = -1;
            for (int i = 0; i < NSLOT; i++) begin
                if (occ_map[i]) begin
                    if (prev < 0) begin
                        best = i;
                    end else begin
                        d = (i - prev) / 2;
                        if (d > best) begin
                            best   = d;
                            choice = prev + d;
                        end
                    end
                    prev = i;
                end
            end
            if (n - 1 - prev > best) begin
                choice = n - 1;
            end
        end
        if (choice >= 0 && choice < NSLOT && !occ_map[choice]) begin
            occ_map[choice] = 1'b1;
            occ_count++;
        end
        res.slot_index = choice[msa_pkg::POS_W-1:0];
        return 1'b1;
    endfunction

    function automatic msa_pkg::t_in_item make_random_item(input int alloc_pct);
        msa_pkg::t_in_item it;
        int                held [$];
        it.action   = ($urandom_range(0, 99) < alloc_pct) ? msa_pkg::ACT_ALLOC
                                                          : msa_pkg::ACT_RELEASE;
        it.position = msa_pkg::POS_W'($urandom_range(0, NSLOT - 1));
        if (it.action == msa_pkg::ACT_RELEASE && $urandom_range(0, 99) < 80) begin
            for (int i = 0; i < NSLOT; i++) begin
                if (occ_map[i]) begin
                    held.push_back(i);
                end
            end
            if (held.size() != 0) begin
                it.position = msa_pkg::POS_W'(held[$urandom_range(0, held.size() - 1)]);
            end
        end
        return it;
    endfunction

    task automatic add_row(input t_row_kind kind, input int val, input bit typed,
                           input msa_pkg::t_out_item res);
        t_row r;
        r.kind    = kind;
        r.pos     = msa_pkg::POS_W'(val);
        r.cfg_val = 7'(val);
        r.typed   = typed;
        r.res     = res;
        plan.push_back(r);
    endtask

    task automatic drive_item(input msa_pkg::t_in_item it, input bit typed,
                              input msa_pkg::t_out_item res);
        while (gaps_on && $urandom_range(0, 99) < 27) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid     <= 1'b1;
        in_data      <= it;
        in_typed     <= typed;
        in_typed_res <= res;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // drain every expected seat, then let a full scan pass
    task automatic wait_idle();
        in_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending_seats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_slots(input logic [6:0] val);
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        out_stall <= gaps_on && ($urandom_range(0, 99) < 27);
    end

    always @(posedge i_clk) begin
        msa_pkg::t_out_item pred;
        msa_pkg::t_out_item want;
        if (i_rst_n) begin
            if (held_valid && (!o_out_valid || o_out_data !== held_data)) begin
                $error("stalled payload changed: expected %h, got valid %b data %h",
                       held_data, o_out_valid, o_out_data);
                err_count++;
            end
            if (in_valid && !o_in_stall) begin
                if (seat_step(in_data, pred)) begin
                    n_alloc++;
                    pending_seats.push_back(in_typed ? in_typed_res : pred);
                end else begin
                    n_release++;
                end
            end
            if (cfg_valid && o_cfg_ready) begin
                slot_cfg = cfg_data;
                n_cfg++;
            end
            if (o_out_valid && !out_stall) begin
                if (pending_seats.size() == 0) begin
                    $error("unexpected result: slot_index %0d full_res %0d",
                           o_out_data.slot_index, o_out_data.full_res);
                    err_count++;
                end else begin
                    want = pending_seats.pop_front();
                    if (o_out_data.slot_index !== want.slot_index) begin
                        $error("slot_index: expected %0d, got %0d",
                               want.slot_index, o_out_data.slot_index);
                        err_count++;
                    end
                    if (o_out_data.full_res !== want.full_res) begin
                        $error("full_res: expected %0d, got %0d",
                               want.full_res, o_out_data.full_res);
                        err_count++;
                    end
                    if (want.full_res) begin
                        n_full++;
                    end
                end
            end
            held_valid <= o_out_valid && out_stall;
            held_data  <= o_out_data;
        end
    end

    initial begin
        #18_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        msa_pkg::t_out_item seat_full;
        msa_pkg::t_out_item none;
        int                 alloc_pct;
        logic [6:0]         slots;
        seat_full = '{slot_index: '0, full_res: 1'b1};
        none      = '0;

        add_row(ROW_ALLOC,   0,   1'b1, '{slot_index: 6'd0,  full_res: 1'b0});
        add_row(ROW_ALLOC,   0,   1'b1, '{slot_index: 6'd63, full_res: 1'b0});
        add_row(ROW_ALLOC,   0,   1'b0, none);
        add_row(ROW_RELEASE, 63,  1'b0, none);
        add_row(ROW_RELEASE, 63,  1'b0, none);
        add_row(ROW_ALLOC,   0,   1'b0, none);
        add_row(ROW_CFG,     0,   1'b0, none);
        add_row(ROW_ALLOC,   0,   1'b1, seat_full);
        add_row(ROW_RELEASE, 31,  1'b0, none);
        add_row(ROW_CFG,     127, 1'b0, none);
        add_row(ROW_ALLOC,   63,  1'b0, none);
        add_row(ROW_CFG,     3,   1'b0, none);
        add_row(ROW_ALLOC,   0,   1'b1, seat_full);
        add_row(ROW_RELEASE, 63,  1'b0, none);
        add_row(ROW_RELEASE, 0,   1'b0, none);
        add_row(ROW_ALLOC,   0,   1'b1, seat_full);
        add_row(ROW_CFG,     64,  1'b0, none);
        add_row(ROW_RELEASE, 31,  1'b0, none);
        add_row(ROW_RELEASE, 63,  1'b0, none);
        add_row(ROW_ALLOC,   0,   1'b0, none);
        add_row(ROW_ALLOC,   0,   1'b0, none);
        add_row(ROW_CFG,     30,  1'b0, none);
        add_row(ROW_ALLOC,   0,   1'b0, none);
        add_row(ROW_CFG,     1,   1'b0, none);
        add_row(ROW_ALLOC,   0,   1'b1, seat_full);
        add_row(ROW_RELEASE, 63,  1'b0, none);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_CFG) begin
                wait_idle();
                write_slots(plan[k].cfg_val);
            end else begin
                drive_item('{action: (plan[k].kind == ROW_RELEASE) ? msa_pkg::ACT_RELEASE
                                                                   : msa_pkg::ACT_ALLOC,
                             position: plan[k].pos}, plan[k].typed, plan[k].res);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       slots = 7'd64;
                1:       slots = 7'd1;
                2:       slots = 7'd2;
                3:       slots = 7'd127;
                4:       slots = 7'd0;
                6:       slots = 7'd65;
                default: slots = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                             : 7'($urandom_range(1, 64));
            endcase
            gaps_on   = (ph != 5);
            alloc_pct = $urandom_range(40, 75);
            wait_idle();
            write_slots(slots);
            for (int j = 0; j < PHASE_LEN; j++) begin
                drive_item(make_random_item(alloc_pct), 1'b0, none);
            end
        end
        gaps_on = 1'b1;
        wait_idle();

        $display("Covered %0d seat requests (%0d with the room full) and %0d releases",
                 n_alloc, n_full, n_release);
        $display("under %0d slot-count writes, with random idling on both channels.", n_cfg);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
